// ----- rtl/esf_pkg.sv -----
// Package: widths, types, register codes and helper functions for the evade steering block.
`default_nettype none
package esf_pkg;

  localparam int CB     = 24;            // coordinate width
  localparam int FB     = 8;             // fraction bits of coordinates
  localparam int PR_W   = 16;            // prediction factor width (Q8.8)
  localparam int PR_FB  = 8;             // prediction fraction bits
  localparam int MS_W   = 23;            // max speed width
  localparam int PAN_W  = 23;            // panic range width
  localparam int CFG_W  = 23;            // config data width
  localparam int IDX_W  = 2;             // config index width
  localparam int MAG_W  = CB - 1;        // offset magnitude width
  localparam int PROD_W = CB + PR_W + 1; // velocity times prediction
  localparam int OFF_W  = PROD_W + 1;    // raw offset width
  localparam int SQ_W   = 2 * MAG_W;     // square of a magnitude
  localparam int RAD_W  = 2 * CB;        // sqrt radicand, even width
  localparam int RT_W   = CB;            // sqrt root width = number of sqrt cells
  localparam int REM_W  = RT_W + 2;      // sqrt partial remainder
  localparam int DIV_W  = CB;            // divisor/quotient width = number of divide cells
  localparam int NUM_W  = 2 * CB - 1;    // dividend width

  typedef enum logic [IDX_W-1:0] {
    REG_MAX_SPEED   = 2'd0,
    REG_PREDICTION  = 2'd1,
    REG_PANIC_RANGE = 2'd2
  } reg_idx_t;

  typedef logic signed [CB-1:0] coord_t;

  // Per-request data that rides along with the arithmetic
  typedef struct packed {
    logic             sx;     // offset x negative
    logic             sy;     // offset y negative
    logic             far;    // offset beyond any panic range
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    coord_t           svx;
    coord_t           svy;
  } side_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [RT_W-1:0]  root;
  } sqrt_st_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] q;
  } div_lane_t;

  // One restoring-division step: returns {new remainder, quotient bit}
  function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                              input logic nb,
                                              input logic [DIV_W-1:0] d);
    logic [DIV_W:0] r2;
    logic [DIV_W:0] diff;
    r2   = {rem, nb};
    diff = r2 - {1'b0, d};
    if (r2 >= {1'b0, d}) begin
      div_step = {diff[DIV_W-1:0], 1'b1};
    end else begin
      div_step = {r2[DIV_W-1:0], 1'b0};
    end
  endfunction

  // Saturate to the coordinate range: returns {clipped, value}
  function automatic logic [CB:0] sat_coord(input logic signed [CB+1:0] v);
    logic signed [CB+1:0] hi;
    logic signed [CB+1:0] lo;
    hi = (CB+2)'((64'sd1 <<< (CB - 1)) - 64'sd1);
    lo = -hi - (CB+2)'(1);
    if (v > hi) begin
      sat_coord = {1'b1, hi[CB-1:0]};
    end else if (v < lo) begin
      sat_coord = {1'b1, lo[CB-1:0]};
    end else begin
      sat_coord = {1'b0, v[CB-1:0]};
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/esf_if.sv -----
// Interfaces: input request channel and result channel.
`default_nettype none
interface esf_in_if import esf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t self_pos_x;
  coord_t self_pos_y;
  coord_t self_vel_x;
  coord_t self_vel_y;
  coord_t chaser_pos_x;
  coord_t chaser_pos_y;
  coord_t chaser_vel_x;
  coord_t chaser_vel_y;

  modport source (output valid, self_pos_x, self_pos_y, self_vel_x, self_vel_y,
                  chaser_pos_x, chaser_pos_y, chaser_vel_x, chaser_vel_y,
                  input ready);
  modport sink (input valid, self_pos_x, self_pos_y, self_vel_x, self_vel_y,
                chaser_pos_x, chaser_pos_y, chaser_vel_x, chaser_vel_y,
                output ready);
endinterface

interface esf_out_if import esf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t force_x;
  coord_t force_y;
  logic   fleeing;
  logic   saturated;

  modport source (output valid, force_x, force_y, fleeing, saturated, input ready);
  modport sink (input valid, force_x, force_y, fleeing, saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/esf_sqrt_cell.sv -----
// Square root cell: one root bit per cell, digit-by-digit.
`default_nettype none
module esf_sqrt_cell import esf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire logic     vld_i,
  input  wire sqrt_st_t st_i,
  input  wire side_t    side_i,
  output logic          vld_o,
  output sqrt_st_t      st_o,
  output side_t         side_o
);

  logic [REM_W+1:0] cur;
  logic [REM_W+1:0] trial;
  sqrt_st_t         st_nxt;

  always_comb begin
    cur          = {st_i.rem, st_i.rad[RAD_W-1 -: 2]};
    trial        = cur - {2'b00, st_i.root, 2'b01};
    st_nxt.rad   = {st_i.rad[RAD_W-3:0], 2'b00};
    if (!trial[REM_W+1]) begin
      st_nxt.rem  = trial[REM_W-1:0];
      st_nxt.root = {st_i.root[RT_W-2:0], 1'b1};
    end else begin
      st_nxt.rem  = cur[REM_W-1:0];
      st_nxt.root = {st_i.root[RT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_o   <= st_nxt;
      side_o <= side_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/esf_div_cell.sv -----
// Divide cell: one quotient bit per cell for both force components.
`default_nettype none
module esf_div_cell import esf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             vld_i,
  input  wire logic [RT_W-1:0]  dist_i,
  input  wire div_lane_t        lx_i,
  input  wire div_lane_t        ly_i,
  input  wire side_t            side_i,
  output logic                  vld_o,
  output logic [RT_W-1:0]       dist_o,
  output div_lane_t             lx_o,
  output div_lane_t             ly_o,
  output side_t                 side_o
);

  logic [DIV_W:0] sx;
  logic [DIV_W:0] sy;
  div_lane_t      lx_nxt;
  div_lane_t      ly_nxt;

  always_comb begin
    sx         = div_step(lx_i.rem, lx_i.num[DIV_W-1], dist_i);
    sy         = div_step(ly_i.rem, ly_i.num[DIV_W-1], dist_i);
    lx_nxt.rem = sx[DIV_W:1];
    lx_nxt.num = {lx_i.num[DIV_W-2:0], 1'b0};
    lx_nxt.q   = {lx_i.q[DIV_W-2:0], sx[0]};
    ly_nxt.rem = sy[DIV_W:1];
    ly_nxt.num = {ly_i.num[DIV_W-2:0], 1'b0};
    ly_nxt.q   = {ly_i.q[DIV_W-2:0], sy[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_o <= dist_i;
      lx_o   <= lx_nxt;
      ly_o   <= ly_nxt;
      side_o <= side_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/evade_steering_force_top.sv -----
// Top level: evade steering force pipeline.
//
// Usage
//   in_ch  : one request per accepted valid/ready beat, own and pursuer
//            position/velocity in signed Q15.8.
//   out_ch : one result per request, in order: force x/y, fleeing, saturated.
//   cfg_*  : write-only registers (max_speed, prediction, panic_range),
//            written when cfg_we is high; change them only while idle.
// Pipeline: from the accepting edge to out_ch.valid a request passes 3 front
//   stages, 24 square-root cells, 1 numerator stage, 24 divide cells and the
//   output register.
// Throughput: one request per cycle unless the output stalls; every stage is a
//   register and the root and quotient come from rows of cells, one bit per cell.
// Reset: rst_n (synchronous, low) clears the pipe valid bits and loads the
//   register defaults (max_speed 100.0, prediction 0, panic_range 300.0).
// Stall: the whole pipe holds while out_ch.valid is high and out_ch.ready
//   is low; in_ch.ready drops in the same cycle, so nothing is lost.
// An offset component of magnitude 2^23 or more is flagged far: its
//   distance already exceeds any panic range, so the result is zero.
`default_nettype none
module evade_steering_force_top import esf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  esf_in_if.sink                in_ch,
  esf_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam logic signed [OFF_W-1:0] OFF_LIM = OFF_W'((64'sd1 <<< MAG_W) - 64'sd1);

  // Configuration registers
  logic [MS_W-1:0]  ms_r;
  logic [PR_W-1:0]  pr_r;
  logic [PAN_W-1:0] pan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r  <= MS_W'(25600);
      pr_r  <= '0;
      pan_r <= PAN_W'(76800);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_MAX_SPEED:   ms_r  <= cfg_data[MS_W-1:0];
        REG_PREDICTION:  pr_r  <= cfg_data[PR_W-1:0];
        REG_PANIC_RANGE: pan_r <= cfg_data[PAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipe advances unless the output register is held
  logic adv;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 1: pursuer velocity times prediction factor
  logic                     s1_vld_r;
  logic signed [PROD_W-1:0] prod_x_r, prod_y_r;
  coord_t                   cpx_r, cpy_r, spx_r, spy_r, svx1_r, svy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_x_r <= in_ch.chaser_vel_x * $signed({1'b0, pr_r});
      prod_y_r <= in_ch.chaser_vel_y * $signed({1'b0, pr_r});
      cpx_r    <= in_ch.chaser_pos_x;
      cpy_r    <= in_ch.chaser_pos_y;
      spx_r    <= in_ch.self_pos_x;
      spy_r    <= in_ch.self_pos_y;
      svx1_r   <= in_ch.self_vel_x;
      svy1_r   <= in_ch.self_vel_y;
    end
  end

  // Stage 2: round prediction, form offset, magnitude and far flag
  logic signed [PROD_W-1:0] rnd_x, rnd_y, prd_x, prd_y;
  logic signed [OFF_W-1:0]  dx, dy;
  logic [OFF_W-1:0]         adx, ady;
  side_t                    side2_nxt, side2_r;
  logic                     s2_vld_r;

  always_comb begin
    rnd_x = prod_x_r + PROD_W'(1 << (PR_FB - 1));
    rnd_y = prod_y_r + PROD_W'(1 << (PR_FB - 1));
    prd_x = rnd_x >>> PR_FB;
    prd_y = rnd_y >>> PR_FB;
    dx    = OFF_W'(cpx_r) + OFF_W'(prd_x) - OFF_W'(spx_r);
    dy    = OFF_W'(cpy_r) + OFF_W'(prd_y) - OFF_W'(spy_r);
    adx   = dx[OFF_W-1] ? -dx : dx;
    ady   = dy[OFF_W-1] ? -dy : dy;
    side2_nxt.sx    = dx[OFF_W-1];
    side2_nxt.sy    = dy[OFF_W-1];
    side2_nxt.far   = (dx > OFF_LIM) || (dx < -OFF_LIM) ||
                      (dy > OFF_LIM) || (dy < -OFF_LIM);
    side2_nxt.mag_x = adx[MAG_W-1:0];
    side2_nxt.mag_y = ady[MAG_W-1:0];
    side2_nxt.svx   = svx1_r;
    side2_nxt.svy   = svy1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side2_r <= side2_nxt;
    end
  end

  // Stage 3: squares of the magnitudes
  logic [SQ_W-1:0] sqx_r, sqy_r;
  side_t           side3_r;
  logic            s3_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r   <= side2_r.mag_x * side2_r.mag_x;
      sqy_r   <= side2_r.mag_y * side2_r.mag_y;
      side3_r <= side2_r;
    end
  end

  // Square root: a row of RT_W cells
  sqrt_st_t sq_st   [0:RT_W];
  side_t    sq_side [0:RT_W];
  logic     sq_vld  [0:RT_W];

  always_comb begin
    sq_st[0].rad  = RAD_W'(sqx_r) + RAD_W'(sqy_r);
    sq_st[0].rem  = '0;
    sq_st[0].root = '0;
    sq_side[0]    = side3_r;
    sq_vld[0]     = s3_vld_r;
  end

  for (genvar i = 0; i < RT_W; i++) begin : g_sqrt
    esf_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (sq_vld[i]),
      .st_i   (sq_st[i]),
      .side_i (sq_side[i]),
      .vld_o  (sq_vld[i+1]),
      .st_o   (sq_st[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // Stage 5: dividends mag * max_speed + dist / 2
  logic [NUM_W-1:0] numx_r, numy_r;
  logic [RT_W-1:0]  dist5_r;
  side_t            side5_r;
  logic             s5_vld_r;
  logic [RT_W-1:0]  root;

  assign root = sq_st[RT_W].root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (adv) begin
      s5_vld_r <= sq_vld[RT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      numx_r  <= NUM_W'(sq_side[RT_W].mag_x) * NUM_W'(ms_r) + NUM_W'(root >> 1);
      numy_r  <= NUM_W'(sq_side[RT_W].mag_y) * NUM_W'(ms_r) + NUM_W'(root >> 1);
      dist5_r <= root;
      side5_r <= sq_side[RT_W];
    end
  end

  // Division: a row of DIV_W cells, quotient below 2^DIV_W since mag <= dist
  div_lane_t       dv_x    [0:DIV_W];
  div_lane_t       dv_y    [0:DIV_W];
  logic [RT_W-1:0] dv_dist [0:DIV_W];
  side_t           dv_side [0:DIV_W];
  logic            dv_vld  [0:DIV_W];

  always_comb begin
    dv_x[0].rem = DIV_W'(numx_r[NUM_W-1:DIV_W]);
    dv_x[0].num = numx_r[DIV_W-1:0];
    dv_x[0].q   = '0;
    dv_y[0].rem = DIV_W'(numy_r[NUM_W-1:DIV_W]);
    dv_y[0].num = numy_r[DIV_W-1:0];
    dv_y[0].q   = '0;
    dv_dist[0]  = dist5_r;
    dv_side[0]  = side5_r;
    dv_vld[0]   = s5_vld_r;
  end

  for (genvar j = 0; j < DIV_W; j++) begin : g_div
    esf_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (dv_vld[j]),
      .dist_i (dv_dist[j]),
      .lx_i   (dv_x[j]),
      .ly_i   (dv_y[j]),
      .side_i (dv_side[j]),
      .vld_o  (dv_vld[j+1]),
      .dist_o (dv_dist[j+1]),
      .lx_o   (dv_x[j+1]),
      .ly_o   (dv_y[j+1]),
      .side_o (dv_side[j+1])
    );
  end

  // Output stage: desired velocity, subtract own velocity, saturate
  side_t                sd;
  logic [RT_W-1:0]      dist_w;
  logic signed [CB+1:0] des_x, des_y, fx_w, fy_w;
  logic [CB:0]          sat_x, sat_y;
  logic                 flee;
  logic                 out_vld_r;
  coord_t               fx_r, fy_r;
  logic                 flee_r, sat_r;

  always_comb begin
    sd     = dv_side[DIV_W];
    dist_w = dv_dist[DIV_W];
    des_x  = (dist_w == '0) ? '0 : (sd.sx ? $signed({2'b00, dv_x[DIV_W].q})
                                          : -$signed({2'b00, dv_x[DIV_W].q}));
    des_y  = (dist_w == '0) ? '0 : (sd.sy ? $signed({2'b00, dv_y[DIV_W].q})
                                          : -$signed({2'b00, dv_y[DIV_W].q}));
    fx_w   = des_x - (CB+2)'(sd.svx);
    fy_w   = des_y - (CB+2)'(sd.svy);
    sat_x  = sat_coord(fx_w);
    sat_y  = sat_coord(fy_w);
    flee   = !sd.far && (dist_w < RT_W'(pan_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_vld[DIV_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fx_r   <= flee ? sat_x[CB-1:0] : '0;
      fy_r   <= flee ? sat_y[CB-1:0] : '0;
      flee_r <= flee;
      sat_r  <= flee && (sat_x[CB] || sat_y[CB]);
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.force_x   = fx_r;
  assign out_ch.force_y   = fy_r;
  assign out_ch.fleeing   = flee_r;
  assign out_ch.saturated = sat_r;

endmodule
`default_nettype wire

// ----- rtl/esf_checker.sv -----
// Port-level checker for the evade steering block, bound to the top level.
`default_nettype none
module esf_checker import esf_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  input wire logic   in_ready,
  input wire logic   out_valid,
  input wire logic   out_ready,
  input wire coord_t force_x,
  input wire coord_t force_y,
  input wire logic   fleeing,
  input wire logic   saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(force_x) && $stable(force_y)
      && $stable(fleeing) && $stable(saturated))
    else $error("result changed while stalled");

  a_no_flee_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !fleeing |-> force_x == '0 && force_y == '0 && !saturated)
    else $error("nonzero force outside panic range");

  a_sat_flee: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |-> fleeing)
    else $error("saturated without fleeing");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind evade_steering_force_top esf_checker u_esf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .force_x   (out_ch.force_x),
  .force_y   (out_ch.force_y),
  .fleeing   (out_ch.fleeing),
  .saturated (out_ch.saturated)
);
`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for the evade steering force block: random and directed requests checked against a predictor.
`default_nettype none
module testbench;
  import esf_pkg::*;

  typedef struct packed {
    coord_t spx, spy, svx, svy, cpx, cpy, cvx, cvy;
  } agent_req_t;

  typedef struct packed {
    coord_t fx;
    coord_t fy;
    logic   flee;
    logic   sat;
  } steer_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  esf_in_if  in_ch ();
  esf_out_if out_ch ();

  evade_steering_force_top uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // predictor's copy of the registers
  longint unsigned speed_reg, look_reg, panic_reg;

  agent_req_t req_q[$];      // requests waiting to be driven
  steer_res_t force_q[$];    // expected forces, oldest first
  int errors;
  int unsigned cycles;
  bit calm;                  // no random idling on either side
  bit hold_off;              // sender holds until the pipe drains

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offset component: chaser pos + rounded(chaser vel * look) - own pos, clamped to +/-(2^31 - 1)
  function automatic longint offset_of(coord_t cp, coord_t cv, coord_t sp);
    longint prod;
    longint pv;
    longint d;
    prod = longint'(cv) * longint'(look_reg) + 128;
    pv = prod >>> 8;
    d = longint'(cp) + pv - longint'(sp);
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483647) d = -64'sd2147483647;
    return d;
  endfunction

  function automatic longint unsigned root_of(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // flee velocity component: -(d * speed / dlen), ties away from zero
  function automatic longint flee_comp(longint d, longint unsigned dlen);
    longint unsigned mag;
    longint unsigned q;
    if (dlen == 0) return 0;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = (mag * speed_reg + dlen / 2) / dlen;
    return (d < 0) ? longint'(q) : -longint'(q);
  endfunction

  function automatic steer_res_t evade_force(agent_req_t r);
    steer_res_t o;
    longint dx, dy, fx, fy;
    longint unsigned ax, ay, dlen;
    o = '0;
    dx = offset_of(r.cpx, r.cvx, r.spx);
    dy = offset_of(r.cpy, r.cvy, r.spy);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    dlen = root_of(ax * ax + ay * ay);
    if (dlen >= panic_reg) return o;
    fx = flee_comp(dx, dlen) - longint'(r.svx);
    fy = flee_comp(dy, dlen) - longint'(r.svy);
    if (fx > 8388607) begin fx = 8388607; o.sat = 1'b1; end
    if (fx < -8388608) begin fx = -8388608; o.sat = 1'b1; end
    if (fy > 8388607) begin fy = 8388607; o.sat = 1'b1; end
    if (fy < -8388608) begin fy = -8388608; o.sat = 1'b1; end
    o.fx = coord_t'(fx);
    o.fy = coord_t'(fy);
    o.flee = 1'b1;
    return o;
  endfunction

  // driver: the predictor runs on the accepting edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        force_q.push_back(evade_force({in_ch.self_pos_x, in_ch.self_pos_y,
          in_ch.self_vel_x, in_ch.self_vel_y, in_ch.chaser_pos_x, in_ch.chaser_pos_y,
          in_ch.chaser_vel_x, in_ch.chaser_vel_y}));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (req_q.size() > 0 && !hold_off && (calm || $urandom_range(99) >= 18)) begin
          agent_req_t r;
          r = req_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.self_pos_x <= r.spx;   in_ch.self_pos_y <= r.spy;
          in_ch.self_vel_x <= r.svx;   in_ch.self_vel_y <= r.svy;
          in_ch.chaser_pos_x <= r.cpx; in_ch.chaser_pos_y <= r.cpy;
          in_ch.chaser_vel_x <= r.cvx; in_ch.chaser_vel_y <= r.cvy;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (force_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result fx=%0d fy=%0d", out_ch.force_x,
                                     out_ch.force_y);
        end else begin
          steer_res_t e;
          e = force_q.pop_front();
          if (e.fx !== out_ch.force_x || e.fy !== out_ch.force_y ||
              e.flee !== out_ch.fleeing || e.sat !== out_ch.saturated) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp fx=%0d fy=%0d flee=%0b sat=%0b got %0d %0d %0b %0b",
                       e.fx, e.fy, e.flee, e.sat, out_ch.force_x, out_ch.force_y,
                       out_ch.fleeing, out_ch.saturated);
          end
        end
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 18);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, longint unsigned val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_SPEED:   speed_reg = val & 23'h7FFFFF;
      REG_PREDICTION:  look_reg = val & 16'hFFFF;
      REG_PANIC_RANGE: panic_reg = val & 23'h7FFFFF;
      default: ;
    endcase
  endtask

  // wait for the pipe to drain; the extra cycles cover the latency
  task automatic drain();
    while (req_q.size() > 0 || in_ch.valid || force_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic coord_t rnd_coord(int span);
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(2 * span)) - span);
      2: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      default: return coord_t'($signed($urandom_range(4096)) - 2048);
    endcase
  endfunction

  // mostly near encounters so that the flee path is exercised
  function automatic agent_req_t rnd_req(int span);
    agent_req_t r;
    r.spx = rnd_coord(8388607); r.spy = rnd_coord(8388607);
    r.svx = rnd_coord(span);    r.svy = rnd_coord(span);
    r.cvx = rnd_coord(span);    r.cvy = rnd_coord(span);
    if ($urandom_range(9) < 7) begin
      r.cpx = r.spx + coord_t'($signed($urandom_range(2 * span)) - span);
      r.cpy = r.spy + coord_t'($signed($urandom_range(2 * span)) - span);
    end else begin
      r.cpx = rnd_coord(8388607); r.cpy = rnd_coord(8388607);
    end
    return r;
  endfunction

  task automatic run_batch(int n, int span);
    repeat (n) req_q.push_back(rnd_req(span));
  endtask

  initial begin
    agent_req_t r;
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    hold_off = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_MAX_SPEED;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.self_pos_x = '0; in_ch.self_pos_y = '0;
    in_ch.self_vel_x = '0; in_ch.self_vel_y = '0;
    in_ch.chaser_pos_x = '0; in_ch.chaser_pos_y = '0;
    in_ch.chaser_vel_x = '0; in_ch.chaser_vel_y = '0;
    out_ch.ready = 1'b0;
    speed_reg = 25600;
    look_reg = 0;
    panic_reg = 76800;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests at reset defaults
    r = '0;
    req_q.push_back(r);                          // zero distance
    r.svx = 24'sh7FFFFF; r.svy = 24'sh800000;
    req_q.push_back(r);                          // zero distance, clipped
    r = '0; r.cpx = 24'sd256;
    req_q.push_back(r);                          // close, straight along x
    r = '0; r.cpy = -24'sd1000; r.svx = 24'sh7FFFFF;
    req_q.push_back(r);
    r = '0; r.cpx = 24'sd76800;
    req_q.push_back(r);                          // exactly at panic range
    r.cpx = 24'sd76799;
    req_q.push_back(r);                          // just inside
    r = '0; r.spx = 24'sh800000; r.cpx = 24'sh7FFFFF; r.spy = 24'sh7FFFFF;
    r.cpy = 24'sh800000;
    req_q.push_back(r);                          // huge offset, far
    drain();

    // full look-ahead and extreme velocities
    write_reg(REG_PREDICTION, 16'hFFFF);
    write_reg(REG_MAX_SPEED, 23'h7FFFFF);
    write_reg(REG_PANIC_RANGE, 23'h7FFFFF);
    r = '0; r.cvx = 24'sh7FFFFF; r.cvy = 24'sh800000;
    req_q.push_back(r);                          // predicted offset beyond any panic range
    r = '0; r.cvx = -24'sd1; r.cpx = 24'sd3;
    req_q.push_back(r);                          // rounding of predicted point
    r = '0; r.cpx = 24'sd5; r.cpy = -24'sd7; r.svx = 24'sh800000;
    req_q.push_back(r);
    run_batch(8, 4096);
    drain();

    // zero panic range: nothing ever flees
    write_reg(REG_PANIC_RANGE, 0);
    write_reg(REG_MAX_SPEED, 0);
    run_batch(6, 1000);
    drain();

    // random phases through several settings; one calm stretch
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_MAX_SPEED, (ph == 1) ? 23'h7FFFFF : $urandom_range(23'h7FFFFF) >> $urandom_range(14));
      write_reg(REG_PREDICTION, (ph == 2) ? 0 : $urandom_range(16'hFFFF) >> $urandom_range(12));
      write_reg(REG_PANIC_RANGE, (ph == 3) ? 23'h7FFFFF :
                $urandom_range(23'h7FFFFF) >> $urandom_range(8));
      calm = (ph == 4);
      run_batch(50, 1 << (8 + 2 * ph));
      // sender holds until every expected result has come
      while (req_q.size() > 0 || in_ch.valid) @(posedge clk);
      hold_off = 1'b1;
      while (force_q.size() > 0) @(posedge clk);
      hold_off = 1'b0;
      run_batch(50, 1 << (6 + 3 * ph));
      drain();
    end
    calm = 1'b0;

    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
